// File: hdl/psd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and codes for the point to segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int DIST_BITS   = 34;
    localparam int REGION_BITS = 2;

    typedef enum logic [REGION_BITS-1:0] {
        REGION_START    = 2'd0,
        REGION_END      = 2'd1,
        REGION_INTERIOR = 2'd2
    } t_region;

endpackage

// File: hdl/psd_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_div_stage
// One restoring step of the fraction divider, registered, with stall.
// Carries side data alongside the partial remainder and quotient.
// ----------------------------------------------------------------------------
module psd_div_stage #(
    parameter int DEN_BITS  = 34,
    parameter int Q_BITS    = 16,
    parameter int SIDE_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [DEN_BITS-1:0]  i_rem,
    input  logic [DEN_BITS-1:0]  i_den,
    input  logic [Q_BITS-1:0]    i_quo,
    input  logic [SIDE_BITS-1:0] i_side,
    output logic                 o_valid,
    output logic [DEN_BITS-1:0]  o_rem,
    output logic [DEN_BITS-1:0]  o_den,
    output logic [Q_BITS-1:0]    o_quo,
    output logic [SIDE_BITS-1:0] o_side
);
    logic [DEN_BITS:0] n_shift;
    logic              n_ge;

    always_comb begin
        n_shift = {i_rem, 1'b0};
        n_ge    = n_shift >= {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_ge ? DEN_BITS'(n_shift - {1'b0, i_den}) : n_shift[DEN_BITS-1:0];
            o_den  <= i_den;
            o_quo  <= {i_quo[Q_BITS-2:0], n_ge};
            o_side <= i_side;
        end
    end
endmodule

// File: hdl/point_segment_distance_squared_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance_squared_unit
// Squared distance from a 3D point to a segment, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one transfer per cycle while not stalled and returns one result per
// item, in order. The restoring divider takes one quotient bit per stage. All
// stages advance together when the output register is empty or being taken.
module point_segment_distance_squared_unit #(
    parameter int COORD_BITS  = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [COORD_BITS-1:0]         i_point_x,
    input  logic signed [COORD_BITS-1:0]         i_point_y,
    input  logic signed [COORD_BITS-1:0]         i_point_z,
    input  logic signed [COORD_BITS-1:0]         i_seg_a_x,
    input  logic signed [COORD_BITS-1:0]         i_seg_a_y,
    input  logic signed [COORD_BITS-1:0]         i_seg_a_z,
    input  logic signed [COORD_BITS-1:0]         i_seg_b_x,
    input  logic signed [COORD_BITS-1:0]         i_seg_b_y,
    input  logic signed [COORD_BITS-1:0]         i_seg_b_z,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [psd_pkg::DIST_BITS-1:0]        o_dist_sq,
    output logic [psd_pkg::REGION_BITS-1:0]      o_region
);
    import psd_pkg::*;

    localparam int DB = COORD_BITS + 1;          // difference width
    localparam int PB = 2 * DB;                  // product width
    localparam int SB = PB + 2;                  // sum of three products
    localparam int QB = T_FRAC_BITS;
    localparam int MB = DB + QB + 1;             // v*t width
    localparam int SIDE = 6 * DB + SB + REGION_BITS;

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // stage 1: differences
    logic                 r1_v;
    logic signed [DB-1:0] r1_vx, r1_vy, r1_vz, r1_wx, r1_wy, r1_wz, r1_ux, r1_uy, r1_uz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en) r1_v <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_vx <= DB'(i_seg_b_x) - DB'(i_seg_a_x);
            r1_vy <= DB'(i_seg_b_y) - DB'(i_seg_a_y);
            r1_vz <= DB'(i_seg_b_z) - DB'(i_seg_a_z);
            r1_wx <= DB'(i_point_x) - DB'(i_seg_a_x);
            r1_wy <= DB'(i_point_y) - DB'(i_seg_a_y);
            r1_wz <= DB'(i_point_z) - DB'(i_seg_a_z);
            r1_ux <= DB'(i_point_x) - DB'(i_seg_b_x);
            r1_uy <= DB'(i_point_y) - DB'(i_seg_b_y);
            r1_uz <= DB'(i_point_z) - DB'(i_seg_b_z);
        end
    end

    // stage 2: products
    logic                 r2_v;
    logic signed [PB-1:0] r2_c1p [3];
    logic signed [PB-1:0] r2_c2p [3];
    logic signed [PB-1:0] r2_d0p [3];
    logic signed [PB-1:0] r2_d1p [3];
    logic signed [DB-1:0] r2_vx, r2_vy, r2_vz, r2_wx, r2_wy, r2_wz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en) r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_c1p[0] <= PB'(r1_vx * r1_wx);
            r2_c1p[1] <= PB'(r1_vy * r1_wy);
            r2_c1p[2] <= PB'(r1_vz * r1_wz);
            r2_c2p[0] <= PB'(r1_vx * r1_vx);
            r2_c2p[1] <= PB'(r1_vy * r1_vy);
            r2_c2p[2] <= PB'(r1_vz * r1_vz);
            r2_d0p[0] <= PB'(r1_wx * r1_wx);
            r2_d0p[1] <= PB'(r1_wy * r1_wy);
            r2_d0p[2] <= PB'(r1_wz * r1_wz);
            r2_d1p[0] <= PB'(r1_ux * r1_ux);
            r2_d1p[1] <= PB'(r1_uy * r1_uy);
            r2_d1p[2] <= PB'(r1_uz * r1_uz);
            r2_vx <= r1_vx; r2_vy <= r1_vy; r2_vz <= r1_vz;
            r2_wx <= r1_wx; r2_wy <= r1_wy; r2_wz <= r1_wz;
        end
    end

    // stage 3: sums
    logic                 r3_v;
    logic signed [SB-1:0] r3_c1, r3_c2;
    logic [SB-1:0]        r3_d0, r3_d1;
    logic signed [DB-1:0] r3_vx, r3_vy, r3_vz, r3_wx, r3_wy, r3_wz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en) r3_v <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_c1 <= SB'(r2_c1p[0]) + SB'(r2_c1p[1]) + SB'(r2_c1p[2]);
            r3_c2 <= SB'(r2_c2p[0]) + SB'(r2_c2p[1]) + SB'(r2_c2p[2]);
            r3_d0 <= SB'(r2_d0p[0]) + SB'(r2_d0p[1]) + SB'(r2_d0p[2]);
            r3_d1 <= SB'(r2_d1p[0]) + SB'(r2_d1p[1]) + SB'(r2_d1p[2]);
            r3_vx <= r2_vx; r3_vy <= r2_vy; r3_vz <= r2_vz;
            r3_wx <= r2_wx; r3_wy <= r2_wy; r3_wz <= r2_wz;
        end
    end

    // stage 4: region decision, divider load
    logic                 r4_v;
    t_region              r4_region;
    logic [SB-1:0]        r4_num, r4_den, r4_end_d;
    logic signed [DB-1:0] r4_vx, r4_vy, r4_vz, r4_wx, r4_wy, r4_wz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en) r4_v <= r3_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r3_c1 <= 0) begin
                r4_region <= REGION_START;
                r4_end_d  <= r3_d0;
            end else if (r3_c2 <= r3_c1) begin
                r4_region <= REGION_END;
                r4_end_d  <= r3_d1;
            end else begin
                r4_region <= REGION_INTERIOR;
                r4_end_d  <= r3_d0;
            end
            r4_num <= (r3_c1 > 0 && r3_c2 > r3_c1) ? r3_c1 : '0;
            r4_den <= (r3_c2 > 0) ? r3_c2 : SB'(1);
            r4_vx <= r3_vx; r4_vy <= r3_vy; r4_vz <= r3_vz;
            r4_wx <= r3_wx; r4_wy <= r3_wy; r4_wz <= r3_wz;
        end
    end

    // divider chain, side data carries v, w, end distance and region
    logic [QB:0]        dv_v;
    logic [SB-1:0]      dv_rem  [QB+1];
    logic [SB-1:0]      dv_den  [QB+1];
    logic [QB-1:0]      dv_quo  [QB+1];
    logic [SIDE-1:0]    dv_side [QB+1];

    assign dv_v[0]    = r4_v;
    assign dv_rem[0]  = r4_num;
    assign dv_den[0]  = r4_den;
    assign dv_quo[0]  = '0;
    assign dv_side[0] = {r4_vx, r4_vy, r4_vz, r4_wx, r4_wy, r4_wz, r4_end_d, r4_region};

    for (genvar g = 0; g < QB; g++) begin : g_div
        psd_div_stage #(.DEN_BITS(SB), .Q_BITS(QB), .SIDE_BITS(SIDE)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[g]),
            .i_rem   (dv_rem[g]),
            .i_den   (dv_den[g]),
            .i_quo   (dv_quo[g]),
            .i_side  (dv_side[g]),
            .o_valid (dv_v[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_den   (dv_den[g+1]),
            .o_quo   (dv_quo[g+1]),
            .o_side  (dv_side[g+1])
        );
    end

    logic signed [DB-1:0] s_vx, s_vy, s_vz, s_wx, s_wy, s_wz;
    logic [SB-1:0]        s_end_d;
    t_region              s_region;
    always_comb begin
        {s_vx, s_vy, s_vz, s_wx, s_wy, s_wz, s_end_d} = dv_side[QB][SIDE-1:REGION_BITS];
        s_region = t_region'(dv_side[QB][REGION_BITS-1:0]);
    end

    // stage 5: v*t products
    logic                 r5_v;
    t_region              r5_region;
    logic [SB-1:0]        r5_end_d;
    logic signed [MB-1:0] r5_mx, r5_my, r5_mz;
    logic signed [DB-1:0] r5_wx, r5_wy, r5_wz;
    logic signed [MB-1:0] n_t;
    assign n_t = MB'({1'b0, dv_quo[QB]});
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en) r5_v <= dv_v[QB];
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_mx <= MB'(MB'(s_vx) * n_t);
            r5_my <= MB'(MB'(s_vy) * n_t);
            r5_mz <= MB'(MB'(s_vz) * n_t);
            r5_wx <= s_wx; r5_wy <= s_wy; r5_wz <= s_wz;
            r5_region <= s_region;
            r5_end_d  <= s_end_d;
        end
    end

    // stage 6: residual to projection
    logic                 r6_v;
    t_region              r6_region;
    logic [SB-1:0]        r6_end_d;
    logic signed [DB-1:0] r6_ex, r6_ey, r6_ez;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (en) r6_v <= r5_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_ex <= r5_wx - DB'(r5_mx >>> QB);
            r6_ey <= r5_wy - DB'(r5_my >>> QB);
            r6_ez <= r5_wz - DB'(r5_mz >>> QB);
            r6_region <= r5_region;
            r6_end_d  <= r5_end_d;
        end
    end

    // stage 7: squares
    logic                 r7_v;
    t_region              r7_region;
    logic [SB-1:0]        r7_end_d;
    logic [PB-1:0]        r7_sx, r7_sy, r7_sz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (en) r7_v <= r6_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_sx <= PB'(r6_ex * r6_ex);
            r7_sy <= PB'(r6_ey * r6_ey);
            r7_sz <= PB'(r6_ez * r6_ez);
            r7_region <= r6_region;
            r7_end_d  <= r6_end_d;
        end
    end

    // stage 8: output register
    logic [SB-1:0] n_sum;
    assign n_sum = (r7_region == REGION_INTERIOR)
                 ? SB'(r7_sx) + SB'(r7_sy) + SB'(r7_sz) : r7_end_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (en) o_valid <= r7_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_dist_sq <= DIST_BITS'(n_sum);
            o_region  <= r7_region;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_dist_sq) && $stable(o_region))
        else $error("result changed under stall");
    a_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_region != 2'd3)
        else $error("bad region code");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipeline stalled with empty output");
endmodule
